>>> rtl/core/csto_pkg.sv
// ============================================================================
// csto_pkg
// Shared types and constants for the character stream tokenizer: character
// classes, token classes, the front-to-back queue entry and the classifier.
// ============================================================================
package csto_pkg;

    // Field widths of the result item
    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 3;
    localparam int CNT_W   = 20;
    localparam int TEXT_W  = 64;
    localparam int LEN_W   = 4;

    // Saturation limit of the line and token counters
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Keyword registers
    localparam int NUM_KW    = 6;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        KW_A = 3'd0,
        KW_B = 3'd1,
        KW_C = 3'd2,
        KW_D = 3'd3,
        KW_E = 3'd4,
        KW_F = 3'd5
    } t_kw_index;

    // Reset contents: "int", "main", "if", "else", "do", "while"
    localparam logic [TEXT_W-1:0] KW_RESET [NUM_KW] = '{
        64'd7630441,
        64'd1852399981,
        64'd26217,
        64'd1702063205,
        64'd28516,
        64'd435610544247
    };

    // Front-to-back queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // ASCII codes the classifier tests
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_QUEST  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
    localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;

    typedef enum logic [2:0] {
        CC_OPER,
        CC_SPEC,
        CC_DIGIT,
        CC_LETTER,
        CC_NEWLINE,
        CC_OTHER
    } t_char_class;

    typedef enum logic [CLASS_W-1:0] {
        TOK_OPER  = 3'd0,
        TOK_SPEC  = 3'd1,
        TOK_CONST = 3'd2,
        TOK_KEYW  = 3'd3,
        TOK_IDENT = 3'd4
    } t_token_class;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic                eos;
        logic [CHAR_W-1:0]   char_code;
        t_char_class         cclass;
    } t_queue_entry;

    function automatic t_char_class classify(input logic [CHAR_W-1:0] c);
        t_char_class cls;
        case (c) inside
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:         cls = CC_OPER;
            CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN,
            CH_RPAREN, CH_QUEST, CH_AT, CH_BANG, CH_PCT:  cls = CC_SPEC;
            [CH_ZERO:CH_NINE]:                            cls = CC_DIGIT;
            [CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]:         cls = CC_LETTER;
            CH_NL:                                        cls = CC_NEWLINE;
            default:                                      cls = CC_OTHER;
        endcase
        return cls;
    endfunction

endpackage

>>> rtl/core/csto_in_if.sv
// ============================================================================
// csto_in_if
// Input channel: one character or an end-of-stream mark per item.
// ============================================================================
interface csto_in_if
    import csto_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

>>> rtl/core/csto_out_if.sv
// ============================================================================
// csto_out_if
// Output channel: one token per item.
// ============================================================================
interface csto_out_if
    import csto_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] token_class;
    logic [CNT_W-1:0]   line_number;
    logic [CNT_W-1:0]   token_number;
    logic [CHAR_W-1:0]  symbol;
    logic [TEXT_W-1:0]  word_text;
    logic [LEN_W-1:0]   word_length;
    logic               truncated;
    logic               last;

    modport source (
        output valid, output token_class, output line_number, output token_number,
        output symbol, output word_text, output word_length, output truncated,
        output last, input ready
    );
    modport sink (
        input valid, input token_class, input line_number, input token_number,
        input symbol, input word_text, input word_length, input truncated,
        input last, output ready
    );
endinterface

>>> rtl/core/csto_front.sv
// ============================================================================
// csto_front
// Accepts input items, classifies each character and pushes the classified
// item into the front-to-back queue.
// ============================================================================
module csto_front
    import csto_pkg::*;
(
    csto_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_q_push,
    output t_queue_entry   o_q_entry
);

    // Take an item whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;

    // Classify the character on the way in
    always_comb begin
        o_q_entry.eos       = (i_in.kind == KIND_EOS);
        o_q_entry.char_code = i_in.char_code;
        o_q_entry.cclass    = classify(i_in.char_code);
    end

endmodule

>>> rtl/core/csto_queue.sv
// ============================================================================
// csto_queue
// Short FIFO between front and back; push and pop in the same cycle keep
// one item per cycle flowing while the back end keeps popping.
// ============================================================================
module csto_queue
    import csto_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_queue_entry   i_entry,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output t_queue_entry   o_entry
);

    t_queue_entry        r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wp, n_rp;
    logic [QCNT_W-1:0]   n_count;
    logic                do_push, do_pop;

    assign o_full   = (r_count == QCNT_W'(QDEPTH));
    assign o_valid  = (r_count != '0);
    assign o_entry  = r_mem[r_rp];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    // Pointer and count update
    always_comb begin
        n_wp    = do_push ? r_wp + 1'b1 : r_wp;
        n_rp    = do_pop  ? r_rp + 1'b1 : r_rp;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

>>> rtl/core/csto_back.sv
// ============================================================================
// csto_back
// Carries out classified items: builds words, matches keywords, keeps the
// line and token counters and drives the output register.
// ============================================================================
module csto_back
    import csto_pkg::*;
#(
    parameter int WORD_CHARS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [TEXT_W-1:0]     i_cfg_data,
    input  logic                  i_q_valid,
    input  t_queue_entry          i_q_entry,
    output logic                  o_q_pop,
    csto_out_if.source            o_out
);

    localparam int BUF_W = 8 * WORD_CHARS;
    localparam int FILL_W = $clog2(WORD_CHARS + 1);

    // Keyword registers
    logic [TEXT_W-1:0]  r_kw [NUM_KW];

    // Word and counter state
    logic               r_in_word, n_in_word;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_line, n_line;
    logic [CNT_W-1:0]   r_tok, n_tok;

    // Output register
    logic               r_out_valid, n_out_valid;
    t_token_class       r_out_class, n_out_class;
    logic [CNT_W-1:0]   r_out_line, n_out_line;
    logic [CNT_W-1:0]   r_out_tok, n_out_tok;
    logic [CHAR_W-1:0]  r_out_sym, n_out_sym;
    logic [TEXT_W-1:0]  r_out_text, n_out_text;
    logic [LEN_W-1:0]   r_out_len, n_out_len;
    logic               r_out_trunc, n_out_trunc;
    logic               r_out_last, n_out_last;

    logic               step;
    logic               emit;
    logic               is_alnum;
    logic               is_sym;
    logic               kw_hit;
    logic [TEXT_W-1:0]  word_ext;

    // The head item is worked on once the output register can take a result
    assign step     = i_q_valid && (!r_out_valid || o_out.ready);
    assign is_alnum = (i_q_entry.cclass == CC_LETTER) || (i_q_entry.cclass == CC_DIGIT);
    assign is_sym   = !i_q_entry.eos && ((i_q_entry.cclass == CC_OPER) ||
                      (i_q_entry.cclass == CC_SPEC) || (i_q_entry.cclass == CC_DIGIT));
    assign word_ext = TEXT_W'(r_buf);

    // Six keyword comparators in parallel; a zero register never matches
    always_comb begin
        kw_hit = 1'b0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (r_kw[k] != '0 && r_kw[k] == word_ext) begin
                kw_hit = 1'b1;
            end
        end
        kw_hit = kw_hit && !r_ovf;
    end

    // Item processing
    always_comb begin
        n_in_word   = r_in_word;
        n_buf       = r_buf;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_line      = r_line;
        o_q_pop     = 1'b0;
        emit        = 1'b0;
        n_out_class = TOK_IDENT;
        n_out_sym   = '0;
        n_out_text  = '0;
        n_out_len   = '0;
        n_out_trunc = 1'b0;
        n_out_last  = 1'b1;

        if (step) begin
            if (r_in_word && (i_q_entry.eos || !is_alnum)) begin
                // Word ends: emit it; a symbol terminator stays at the head
                // and is emitted on the next step
                emit        = 1'b1;
                n_out_class = kw_hit ? TOK_KEYW : TOK_IDENT;
                n_out_text  = word_ext;
                n_out_len   = LEN_W'(r_fill);
                n_out_trunc = r_ovf;
                n_out_last  = !is_sym;
                n_in_word   = 1'b0;
                n_fill      = '0;
                n_ovf       = 1'b0;
                o_q_pop     = !is_sym;
                if (!i_q_entry.eos && i_q_entry.cclass == CC_NEWLINE &&
                    r_line != CNT_MAX) begin
                    n_line = r_line + 1'b1;
                end
            end else if (i_q_entry.eos) begin
                o_q_pop = 1'b1;
            end else if (r_in_word) begin
                // Extend the word, or flag it once it is full
                o_q_pop = 1'b1;
                if (r_fill < FILL_W'(WORD_CHARS)) begin
                    for (int i = 0; i < WORD_CHARS; i++) begin
                        if (r_fill == FILL_W'(i)) begin
                            n_buf[8*i +: 8] = i_q_entry.char_code;
                        end
                    end
                    n_fill = r_fill + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                o_q_pop = 1'b1;
                case (i_q_entry.cclass)
                    CC_OPER, CC_SPEC, CC_DIGIT: begin
                        emit      = 1'b1;
                        n_out_sym = i_q_entry.char_code;
                        case (i_q_entry.cclass)
                            CC_OPER: n_out_class = TOK_OPER;
                            CC_SPEC: n_out_class = TOK_SPEC;
                            default: n_out_class = TOK_CONST;
                        endcase
                    end
                    CC_LETTER: begin
                        n_in_word = 1'b1;
                        n_buf     = BUF_W'(i_q_entry.char_code);
                        n_fill    = FILL_W'(1);
                        n_ovf     = 1'b0;
                    end
                    CC_NEWLINE: begin
                        if (r_line != CNT_MAX) begin
                            n_line = r_line + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Token counter and output register load
    always_comb begin
        n_tok       = r_tok;
        n_out_line  = r_out_line;
        n_out_tok   = r_out_tok;
        n_out_valid = r_out_valid && !o_out.ready;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_line  = r_line;
            n_out_tok   = r_tok;
            if (r_tok != CNT_MAX) begin
                n_tok = r_tok + 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word   <= 1'b0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_line      <= CNT_W'(1);
            r_tok       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_word   <= n_in_word;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_line      <= n_line;
            r_tok       <= n_tok;
            r_out_valid <= n_out_valid;
        end
    end

    // Word buffer and output payload
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (emit) begin
            r_out_class <= n_out_class;
            r_out_line  <= n_out_line;
            r_out_tok   <= n_out_tok;
            r_out_sym   <= n_out_sym;
            r_out_text  <= n_out_text;
            r_out_len   <= n_out_len;
            r_out_trunc <= n_out_trunc;
            r_out_last  <= n_out_last;
        end
    end

    // Keyword registers; writes beyond the last index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KW; k++) begin
                r_kw[k] <= KW_RESET[k];
            end
        end else if (i_cfg_we) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(k)) begin
                    r_kw[k] <= i_cfg_data;
                end
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.token_class  = r_out_class;
    assign o_out.line_number  = r_out_line;
    assign o_out.token_number = r_out_tok;
    assign o_out.symbol       = r_out_sym;
    assign o_out.word_text    = r_out_text;
    assign o_out.word_length  = r_out_len;
    assign o_out.truncated    = r_out_trunc;
    assign o_out.last         = r_out_last;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WORD_CHARS))
        else $error("word fill beyond capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_in_word && r_fill == FILL_W'(WORD_CHARS)))
        else $error("overflow flagged on a word that is not full");

    a_trunc_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_trunc) |-> (r_out_class == TOK_IDENT))
        else $error("truncated word reported as other than identifier");

    a_line_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_line >= $past(r_line) && r_line != '0))
        else $error("line counter went backward");

    a_sym_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit && !o_q_pop) |=> (i_q_valid && !r_in_word))
        else $error("symbol after word lost from queue head");
`endif

endmodule

>>> rtl/core/character_stream_tokenizer.sv
// ============================================================================
// character_stream_tokenizer
// Lexical analyzer over a stream of ASCII characters, one token per result.
// ============================================================================
// Takes one character (or end-of-stream mark) per cycle while the queue has
// room and emits operator, special-symbol, constant, keyword and identifier
// tokens with line and token numbers. A classifying front end feeds a
// two-entry queue; the back end builds words, runs six keyword comparators in
// parallel and drives one output register, so one item is taken per cycle
// while each item yields at most one token and the output is not stalled. An
// item that ends a word and is itself a token yields two results and holds
// the queue head for both, as the output delivers one token per cycle.
// Keyword registers reset to int, main, if, else, do, while and are written
// at indexes 0 to 5 of the config port; a zero keyword never matches.
// ============================================================================
module character_stream_tokenizer
    import csto_pkg::*;
#(
    parameter int WORD_CHARS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [TEXT_W-1:0]     i_cfg_data,
    csto_in_if.sink               i_in,
    csto_out_if.source            o_out
);

    logic           q_push, q_full, q_pop, q_valid;
    t_queue_entry   q_in_entry, q_out_entry;

    csto_front u_front (
        .i_in      (i_in),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_entry (q_in_entry)
    );

    csto_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out_entry)
    );

    csto_back #(
        .WORD_CHARS (WORD_CHARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_out_entry),
        .o_q_pop    (q_pop),
        .o_out      (o_out)
    );

endmodule

>>> dv/csto_token_checker.sv
// ============================================================================
// csto_token_checker
// Watches the character and token channels of the tokenizer. Every accepted
// character item is run through a cycle-free model of the lexer (own counters,
// word buffer and keyword copies) and the tokens it yields are queued. Every
// accepted token item is compared field by field with the oldest queued one.
// ============================================================================
module csto_token_checker
    import csto_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TEXT_W-1:0]    i_cfg_data,
    csto_in_if                   i_chars,
    csto_out_if                  i_tokens,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int WORD_CHARS = 8;

    typedef struct {
        t_token_class      cls;
        logic [CNT_W-1:0]  line_no;
        logic [CNT_W-1:0]  tok_no;
        logic [CHAR_W-1:0] sym;
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  len;
        logic              trunc;
        logic              last;
    } t_token_rec;

    t_token_rec        token_q [$];
    t_token_rec        step_tok [2];
    int                step_n;
    int                fails = 0;

    // lexer state as the block should hold it
    logic [TEXT_W-1:0] kw_copy [NUM_KW];
    logic [CNT_W-1:0]  line_cnt;
    logic [CNT_W-1:0]  tok_cnt;
    logic [TEXT_W-1:0] word_buf;
    int                word_fill;
    logic              in_word;
    logic              word_ovf;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // token numbers are handed out in emission order and stick at the top
    function void stage_token(input t_token_class cls, input logic [CHAR_W-1:0] sym,
                              input logic [TEXT_W-1:0] text, input logic [LEN_W-1:0] len,
                              input logic trunc);
        t_token_rec t;
        t.cls     = cls;
        t.line_no = line_cnt;
        t.tok_no  = tok_cnt;
        t.sym     = sym;
        t.text    = text;
        t.len     = len;
        t.trunc   = trunc;
        t.last    = 1'b0;
        if (tok_cnt != CNT_MAX)
            tok_cnt++;
        step_tok[step_n] = t;
        step_n++;
    endfunction

    // finished word: keyword only if it fit and equals a nonzero register
    function void close_word();
        t_token_class cls;
        cls = TOK_IDENT;
        if (!word_ovf) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (kw_copy[k] != '0 && kw_copy[k] == word_buf)
                    cls = TOK_KEYW;
            end
        end
        stage_token(cls, '0, word_buf, LEN_W'(word_fill), word_ovf);
        word_buf  = '0;
        word_fill = 0;
        in_word   = 1'b0;
        word_ovf  = 1'b0;
    endfunction

    function void add_letter(input logic [CHAR_W-1:0] c);
        if (word_fill < WORD_CHARS) begin
            word_buf[8*word_fill +: 8] = c;
            word_fill++;
        end else begin
            word_ovf = 1'b1;
        end
    endfunction

    // one accepted character item -> zero, one or two queued tokens
    function void lex_item(input logic kind, input logic [CHAR_W-1:0] c);
        step_n = 0;
        if (kind == KIND_EOS) begin
            if (in_word)
                close_word();
        end else if (in_word && (is_letter(c) || is_digit(c))) begin
            add_letter(c);
        end else begin
            // the character ending a word is classified on its own afterwards
            if (in_word)
                close_word();
            case (c)
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:
                    stage_token(TOK_OPER, c, '0, '0, 1'b0);
                CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
                CH_QUEST, CH_AT, CH_BANG, CH_PCT:
                    stage_token(TOK_SPEC, c, '0, '0, 1'b0);
                default: begin
                    if (is_digit(c)) begin
                        stage_token(TOK_CONST, c, '0, '0, 1'b0);
                    end else if (is_letter(c)) begin
                        in_word   = 1'b1;
                        word_buf  = '0;
                        word_fill = 0;
                        word_ovf  = 1'b0;
                        add_letter(c);
                    end else if (c == CH_NL && line_cnt != CNT_MAX) begin
                        line_cnt++;
                    end
                end
            endcase
        end
        if (step_n > 0)
            step_tok[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            token_q.push_back(step_tok[i]);
    endfunction

    function void check_token();
        t_token_rec e;
        logic       bad;
        if (token_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("unexpected token: cls %0d sym %h text %h",
                         i_tokens.token_class, i_tokens.symbol, i_tokens.word_text);
            return;
        end
        e = token_q.pop_front();
        bad = e.cls != i_tokens.token_class || e.line_no != i_tokens.line_number ||
              e.tok_no != i_tokens.token_number || e.sym != i_tokens.symbol ||
              e.text != i_tokens.word_text || e.len != i_tokens.word_length ||
              e.trunc != i_tokens.truncated || e.last != i_tokens.last;
        if (bad) begin
            fails++;
            if (fails <= 10) begin
                $display("token mismatch exp: cls %0d ln %0d tok %0d sym %h text %h len %0d tr %b lst %b",
                         e.cls, e.line_no, e.tok_no, e.sym, e.text, e.len, e.trunc, e.last);
                $display("               got: cls %0d ln %0d tok %0d sym %h text %h len %0d tr %b lst %b",
                         i_tokens.token_class, i_tokens.line_number, i_tokens.token_number,
                         i_tokens.symbol, i_tokens.word_text, i_tokens.word_length,
                         i_tokens.truncated, i_tokens.last);
            end
        end
    endfunction

    // all sampling at the rising edge, before the block's own updates land
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kw_copy   = KW_RESET;
            line_cnt  = 20'd1;
            tok_cnt   = '0;
            word_buf  = '0;
            word_fill = 0;
            in_word   = 1'b0;
            word_ovf  = 1'b0;
            token_q.delete();
        end else begin
            if (i_chars.valid && i_chars.ready)
                lex_item(i_chars.kind, i_chars.char_code);
            if (i_tokens.valid && i_tokens.ready)
                check_token();
            if (i_cfg_we && i_cfg_idx < NUM_KW)
                kw_copy[i_cfg_idx] = i_cfg_data;
        end
        o_pending    <= token_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> dv/testbench.sv
// ============================================================================
// testbench
// Drives the character stream tokenizer with a short directed text and then
// with random statement-like text (keywords, near misses, long identifiers,
// constants, delimiters, stray bytes, end-of-stream marks) over several
// keyword settings. Both channels idle at random; the token side also holds
// off for long stretches so the block backs up. Checking is done by
// csto_token_checker.
// ============================================================================
module testbench;
    import csto_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 170;

    // indexes past the last keyword register, ignored by the block
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

    localparam logic [CHAR_W-1:0] DELIMS [16] = '{
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_SEMI, CH_LBRACE, CH_RBRACE,
        CH_LPAREN, CH_RPAREN, CH_QUEST, CH_AT, CH_BANG, CH_PCT, CH_NL,
        CH_SPACE, CH_TAB
    };

    bit                   i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TEXT_W-1:0]    i_cfg_data;

    csto_in_if  in_ch ();
    csto_out_if out_ch ();

    int  fail_count;
    int  tok_pending;
    int  cycles     = 0;
    int  items_sent = 0;
    bit  no_idle    = 1'b0;
    bit  hold_req   = 1'b0;

    // keyword contents as last written, used only to build stimulus
    logic [TEXT_W-1:0] kw_val [NUM_KW];

    character_stream_tokenizer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    csto_token_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_chars      (in_ch),
        .i_tokens     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (tok_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return is_letter(c) || (c >= CH_ZERO && c <= CH_NINE);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_letter();
        if ($urandom_range(0, 3) == 0)
            return CH_UC_A + 8'($urandom_range(0, 25));
        return CH_LC_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_alnum();
        if ($urandom_range(0, 4) == 0)
            return CH_ZERO + 8'($urandom_range(0, 9));
        return rand_letter();
    endfunction

    function automatic logic [TEXT_W-1:0] rand_word(input int len);
        logic [TEXT_W-1:0] v;
        v = '0;
        for (int i = 0; i < len; i++)
            v[8*i +: 8] = (i == 0) ? rand_letter() : rand_alnum();
        return v;
    endfunction

    function automatic logic [TEXT_W-1:0] pack_text(input string s);
        logic [TEXT_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len(); i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    // length of a register that spells a lexable word, else 0
    function automatic int word_len(input logic [TEXT_W-1:0] v);
        int n;
        n = 0;
        while (n < 8 && v[8*n +: 8] != '0)
            n++;
        if (n == 0 || (n < 8 && (v >> (8*n)) != '0) || !is_letter(v[7:0]))
            return 0;
        for (int i = 1; i < n; i++)
            if (!is_alnum(v[8*i +: 8]))
                return 0;
        return n;
    endfunction

    // called and returns at a falling edge
    task automatic offer_item(input logic kind, input logic [CHAR_W-1:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.char_code <= c;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_item(KIND_CHAR, s[i]);
    endtask

    task automatic send_packed(input logic [TEXT_W-1:0] v);
        for (int i = 0; i < 8; i++)
            if (v[8*i +: 8] != '0)
                offer_item(KIND_CHAR, v[8*i +: 8]);
    endtask

    task automatic send_ident(input int len);
        for (int i = 0; i < len; i++)
            offer_item(KIND_CHAR, (i == 0) ? rand_letter() : rand_alnum());
    endtask

    // flush any open word, then wait until the block has gone quiet
    task automatic settle();
        offer_item(KIND_EOS, 8'($urandom));
        in_ch.valid <= 1'b0;
        while (tok_pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_kw(input logic [CFG_IDX_W-1:0] idx, input logic [TEXT_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        if (idx < NUM_KW)
            kw_val[idx] = v;
        @(negedge i_clk);
    endtask

    // one random fragment of source text
    task automatic random_phrase();
        int                r;
        int                slot;
        int                n;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            // a word: live keyword, near miss or fresh identifier
            slot = $urandom_range(0, NUM_KW - 1);
            n    = word_len(kw_val[slot]);
            r    = $urandom_range(0, 99);
            if (n > 0 && r < 45) begin
                send_packed(kw_val[slot]);
            end else if (n > 1 && r < 52) begin
                send_packed(kw_val[slot] & ((64'd1 << (8 * (n - 1))) - 64'd1));
            end else if (n > 0 && r < 60) begin
                send_packed(kw_val[slot]);
                offer_item(KIND_CHAR, rand_alnum());
            end else begin
                send_ident(($urandom_range(0, 9) == 0) ? $urandom_range(9, 14)
                                                      : $urandom_range(1, 8));
            end
            // what ends it
            r = $urandom_range(0, 99);
            if (r < 80) begin
                offer_item(KIND_CHAR, DELIMS[$urandom_range(0, 15)]);
            end else if (r < 94) begin
                do
                    c = 8'($urandom);
                while (is_alnum(c));
                offer_item(KIND_CHAR, c);
            end else begin
                offer_item(KIND_EOS, 8'($urandom));
            end
        end else if (r < 65) begin
            n = $urandom_range(1, 3);
            repeat (n) offer_item(KIND_CHAR, CH_ZERO + 8'($urandom_range(0, 9)));
            offer_item(KIND_CHAR, DELIMS[$urandom_range(0, 15)]);
        end else if (r < 85) begin
            offer_item(KIND_CHAR, DELIMS[$urandom_range(0, 15)]);
        end else if (r < 97) begin
            offer_item(KIND_CHAR, 8'($urandom));
        end else begin
            offer_item(KIND_EOS, 8'($urandom));
        end
    endtask

    task automatic run_phase(input int count, input bit with_hold);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if (with_hold && items_sent >= stop - count / 2) begin
                hold_req  = 1'b1;
                with_hold = 1'b0;
            end
            if (!no_idle && $urandom_range(0, 29) == 0)
                no_idle = 1'b1;
            else if (no_idle && $urandom_range(0, 9) == 0)
                no_idle = 1'b0;
            random_phrase();
        end
        no_idle = 1'b0;
        settle();
    endtask

    // token side: random stalls, plus a long hold-off on request
    initial begin
        int quiet;
        quiet = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (quiet > 0) begin
                quiet--;
                out_ch.ready <= 1'b0;
            end else begin
                quiet = pick_gap();
                out_ch.ready <= (quiet == 0);
                if (quiet > 0)
                    quiet--;
            end
        end
    end

    // stimulus and verdict
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = KW_A;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_CHAR;
        in_ch.char_code = '0;
        kw_val          = KW_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: keyword ended by a symbol, long word, every symbol but ), newline
        send_text("while(");
        send_text("zAbcdefg9+");
        send_text("-*/;{}?@!%\n");
        send_text("do");
        settle();
        run_phase(PHASE_ITEMS, 1'b0);

        // full-length keyword, one-letter keyword, duplicates, spare indexes
        write_kw(KW_A, pack_text("abcdefgh"));
        write_kw(KW_B, pack_text("x"));
        write_kw(KW_C, rand_word($urandom_range(2, 7)));
        write_kw(KW_D, rand_word($urandom_range(2, 7)));
        write_kw(KW_E, pack_text("abcdefgh"));
        write_kw(KW_F, rand_word(5));
        write_kw(IDX_SPARE_LO, pack_text("int"));
        write_kw(IDX_SPARE_HI, '1);
        i_cfg_we <= 1'b0;
        send_text("int;abcdefgh x abcdefghi\n");
        run_phase(PHASE_ITEMS, 1'b1);

        // extremes: empty slots, all ones, random bits, widest and narrowest words
        write_kw(KW_A, '0);
        write_kw(KW_B, '1);
        write_kw(KW_C, {$urandom, $urandom});
        write_kw(KW_D, rand_word(8));
        write_kw(KW_E, '0);
        write_kw(KW_F, rand_word(1));
        i_cfg_we <= 1'b0;
        run_phase(PHASE_ITEMS, 1'b0);

        for (int k = 0; k < NUM_KW; k++)
            write_kw(CFG_IDX_W'(k), rand_word($urandom_range(1, 8)));
        i_cfg_we <= 1'b0;
        run_phase(PHASE_ITEMS, 1'b1);

        if (fail_count == 0 && tok_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
